FILE: rtl/set_assoc_tlb_clock_replace_unit_defines.svh
// assertion macros used by the checker of the translation cache
`ifndef SET_ASSOC_TLB_CLOCK_REPLACE_UNIT_DEFINES_SVH
`define SET_ASSOC_TLB_CLOCK_REPLACE_UNIT_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define SATLB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("satlb check failed");

// next-cycle implication, quiet while reset is held
`define SATLB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("satlb check failed");

`endif

FILE: rtl/satlb_pkg.sv
package satlb_pkg;

    // geometry
    localparam int SETS        = 64;
    localparam int WAYS        = 4;
    localparam int PAGE_SHIFT  = 12;
    localparam int ADDR_BITS   = 48;
    localparam int REGION_BITS = 16;
    localparam int LEN_BITS    = 32;
    localparam int ACT_BITS    = 2;

    localparam int SET_BITS  = $clog2(SETS);
    localparam int WAY_BITS  = $clog2(WAYS);
    localparam int PAGE_BITS = ADDR_BITS - PAGE_SHIFT;

    // action codes
    localparam logic [ACT_BITS-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_FILL   = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_EVICT  = 2'd2;

    typedef logic [PAGE_BITS-1:0] t_page;

    // one memory row holds a whole set plus its clock pointer
    typedef struct packed {
        logic [WAY_BITS-1:0]                ptr;
        logic [WAYS-1:0][REGION_BITS-1:0]   regions;
        logic [WAYS-1:0][PAGE_BITS-1:0]     tags;
    } t_row;

    // what the row evaluator needs besides the row
    typedef struct packed {
        t_page               page;
        t_page               first_page;
        t_page               last_page;
        logic [WAY_BITS-1:0] ptr;
        logic [WAYS-1:0]     valid;
    } t_ctx;

    // what the row evaluator reports
    typedef struct packed {
        logic                   hit;
        logic [REGION_BITS-1:0] region;
        logic [WAY_BITS-1:0]    fill_way;
        logic [WAYS-1:0]        evict_hits;
    } t_eval;

endpackage

FILE: rtl/satlb_row_eval.sv
module satlb_row_eval (
    input  satlb_pkg::t_row  i_row,
    input  satlb_pkg::t_ctx  i_ctx,
    output satlb_pkg::t_eval o_eval
);
    import satlb_pkg::*;

    // tag match, victim choice and range compare over the ways of one set
    always_comb begin
        o_eval = '0;

        // lowest matching way wins, so scan from the top down
        for (int k = WAYS - 1; k >= 0; k--) begin
            if (i_ctx.valid[k] && (i_row.tags[k] == i_ctx.page)) begin
                o_eval.hit    = 1'b1;
                o_eval.region = i_row.regions[k];
            end
        end

        // first free way from the clock pointer, else the pointer itself
        o_eval.fill_way = i_ctx.ptr;
        for (int k = WAYS - 1; k >= 0; k--) begin
            if (!i_ctx.valid[WAY_BITS'(int'(i_ctx.ptr) + k)]) begin
                o_eval.fill_way = WAY_BITS'(int'(i_ctx.ptr) + k);
            end
        end

        // pages inside the evict range
        for (int k = 0; k < WAYS; k++) begin
            o_eval.evict_hits[k] = i_ctx.valid[k]
                                 && (i_row.tags[k] >= i_ctx.first_page)
                                 && (i_row.tags[k] <= i_ctx.last_page);
        end
    end

endmodule

FILE: rtl/set_assoc_tlb_clock_replace_unit.sv
// Set-associative translation cache (64 sets of 4 ways, 4 KiB pages) with clock
// replacement. Each input word is a lookup, a fill or a range evict on the page
// number of its address, and yields exactly one result word. Tags, region ids
// and clock pointers live in one row-wide synchronous memory, read into a
// register ahead of evaluation; valid bits are flip-flops cleared by reset,
// so the block is usable straight out of reset with no clearing pass. One
// word is handled at a time: a lookup or fill reads its row, then evaluates
// it and a fill writes the row back; an unused code or a zero-length evict
// goes straight to its result; a range evict reads every set in turn. A
// stalled result is held in the output register and the next word waits for
// it only once its own result is ready.
module set_assoc_tlb_clock_replace_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [satlb_pkg::ACT_BITS-1:0]      i_action,
    input  logic [satlb_pkg::ADDR_BITS-1:0]     i_address,
    input  logic [satlb_pkg::REGION_BITS-1:0]   i_region_id,
    input  logic [satlb_pkg::LEN_BITS-1:0]      i_length,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_hit,
    output logic [satlb_pkg::REGION_BITS-1:0]  o_region_out,
    output logic                                o_done_res
);
    import satlb_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RMW   = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_HOLD  = 3'd4;

    logic [2:0]             r_state, n_state;
    logic [ACT_BITS-1:0]    r_action;
    t_page                  r_page, r_first, r_last;
    logic [REGION_BITS-1:0] r_region_in;
    logic [SET_BITS-1:0]    r_set, r_cnt, r_pend_set;
    logic                   r_pend;
    logic [WAYS-1:0]        r_valid [SETS];
    logic [SETS-1:0]        r_touched;
    t_row                   r_rdata;
    t_row                   mem [SETS];
    logic                   r_ov, r_hit, r_res_hit;
    logic [REGION_BITS-1:0] r_region, r_res_region;

    logic                   accept, out_free, fin, fill_we;
    t_page                  in_page;
    logic [SET_BITS-1:0]    in_set, rd_addr;
    logic [ADDR_BITS:0]     end_sum;
    logic [ADDR_BITS-1:0]   end_addr;
    logic                   fin_hit;
    logic [REGION_BITS-1:0] fin_region;
    t_ctx                   ctx;
    t_eval                  ev;
    t_row                   wrow;

    // input decode and saturated range end
    assign accept   = i_in_valid && o_in_ready;
    assign in_page  = i_address[ADDR_BITS-1:PAGE_SHIFT];
    assign in_set   = in_page[SET_BITS-1:0];
    assign end_sum  = {1'b0, i_address} + (ADDR_BITS + 1)'(i_length)
                    - (ADDR_BITS + 1)'(1);
    assign end_addr = end_sum[ADDR_BITS] ? '1 : end_sum[ADDR_BITS-1:0];

    assign o_in_ready = (r_state == ST_IDLE);
    assign out_free   = !r_ov || i_out_ready;

    // row memory: read ahead, write back on fill
    assign rd_addr = (r_state == ST_SWEEP) ? r_cnt : in_set;
    assign fill_we = (r_state == ST_RMW) && (r_action == ACT_FILL);

    always_comb begin
        wrow                    = r_rdata;
        wrow.tags[ev.fill_way]    = r_page;
        wrow.regions[ev.fill_way] = r_region_in;
        wrow.ptr                  = ev.fill_way + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[rd_addr];
        if (fill_we) begin
            mem[r_set] <= wrow;
        end
    end

    // evaluation of the row just read
    always_comb begin
        ctx.page       = r_page;
        ctx.first_page = r_first;
        ctx.last_page  = r_last;
        ctx.ptr        = r_touched[r_set] ? r_rdata.ptr : '0;
        ctx.valid      = r_pend ? r_valid[r_pend_set] : r_valid[r_set];
    end

    satlb_row_eval u_eval (
        .i_row  (r_rdata),
        .i_ctx  (ctx),
        .o_eval (ev)
    );

    // result of the word that finishes this cycle
    assign fin        = (r_state == ST_RMW) || (r_state == ST_DRAIN);
    assign fin_hit    = (r_state == ST_RMW) && (r_action == ACT_LOOKUP) && ev.hit;
    assign fin_region = fin_hit ? ev.region : '0;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority if (i_action == ACT_LOOKUP || i_action == ACT_FILL) begin
                        n_state = ST_RMW;
                    end else if (i_action == ACT_EVICT && i_length != '0) begin
                        n_state = ST_SWEEP;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_RMW, ST_DRAIN: begin
                n_state = out_free ? ST_IDLE : ST_HOLD;
            end
            ST_SWEEP: begin
                if (r_cnt == SET_BITS'(SETS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == ST_SWEEP);
        end
    end

    // captured word and sweep counter
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action    <= i_action;
            r_page      <= in_page;
            r_set       <= in_set;
            r_region_in <= i_region_id;
            r_first     <= in_page;
            r_last      <= end_addr[ADDR_BITS-1:PAGE_SHIFT];
            r_cnt       <= '0;
            r_res_hit   <= 1'b0;
            r_res_region <= '0;
        end else if (fin && !out_free) begin
            r_res_hit    <= fin_hit;
            r_res_region <= fin_region;
        end
        if (r_state == ST_SWEEP) begin
            r_cnt <= r_cnt + 1'b1;
        end
        r_pend_set <= r_cnt;
    end

    // valid bits and pointer-written flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SETS; s++) begin
                r_valid[s] <= '0;
            end
            r_touched <= '0;
        end else if (r_pend) begin
            r_valid[r_pend_set] <= r_valid[r_pend_set] & ~ev.evict_hits;
        end else if (fill_we) begin
            r_valid[r_set][ev.fill_way] <= 1'b1;
            r_touched[r_set]            <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (fin && out_free) begin
            r_ov     <= 1'b1;
            r_hit    <= fin_hit;
            r_region <= fin_region;
        end else if (r_state == ST_HOLD && out_free) begin
            r_ov     <= 1'b1;
            r_hit    <= r_res_hit;
            r_region <= r_res_region;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_hit        = r_hit;
    assign o_region_out = r_region;
    assign o_done_res   = 1'b1;

endmodule

FILE: rtl/satlb_checker.sv
`include "set_assoc_tlb_clock_replace_unit_defines.svh"

module satlb_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic                                o_hit,
    input logic [satlb_pkg::REGION_BITS-1:0]   o_region_out,
    input logic                                o_done_res
);
    import satlb_pkg::*;

    // a stalled result word stays offered
    `SATLB_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)

    // a stalled result word keeps its region
    `SATLB_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_region_out))

    // a miss never reports a region
    `SATLB_ASSERT_NOW(a_miss_zero, o_out_valid && !o_hit, o_region_out == '0)

    // every result marks its action complete
    `SATLB_ASSERT_NOW(a_done_set, o_out_valid, o_done_res)

    // one word at a time: busy right after an acceptance
    `SATLB_ASSERT_NEXT(a_busy_after, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind set_assoc_tlb_clock_replace_unit satlb_checker u_satlb_checker (.*);
